// ===== rtl/ptrm_pkg.sv =====
// Shared types and constants for the page table range mapper.
// Used by every module of the block; depends on nothing else.
package ptrm_pkg;

    localparam int FRAME_W = 40;
    localparam int VPN_W   = 36;
    localparam int SLOT_W  = 9;
    localparam int COUNT_W = 19;
    localparam int TIU_W   = 7;
    localparam int SIZE_W  = 31;
    localparam logic [SIZE_W-1:0] MAX_LEN = 31'h4000_0000;

    localparam logic CFG_IDX_POOL_BASE = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_NONCANON,
        STATUS_POOL_EMPTY
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MOD,
        ST_ZERO,
        ST_LINK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        LVL_4,
        LVL_3,
        LVL_2,
        LVL_1
    } level_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic [63:0]       virt_addr;
        logic [51:0]       phys_addr;
        logic [SIZE_W-1:0] size_bytes;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] pages_mapped;
        logic [COUNT_W-1:0] pages_already_mapped;
        logic [TIU_W-1:0]   tables_in_use;
    } result_t;

endpackage

// ===== rtl/ptrm_table_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
// Depends on ptrm_pkg for the entry type.
module ptrm_table_ram
    import ptrm_pkg::*;
#(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ptrm_frame_mod.sv =====
// Remainder of a 40-bit frame offset by the pool size, ten bits per step, each step being
// a reciprocal multiply for the step quotient, then a multiply and subtract for the remainder.
// Depends on ptrm_pkg for the frame width.
module ptrm_frame_mod
    import ptrm_pkg::*;
#(
    parameter int TABLE_PAGES = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [FRAME_W-1:0]             dividend,
    output logic                           done,
    output logic [$clog2(TABLE_PAGES)-1:0] rem
);

    localparam int PW      = $clog2(TABLE_PAGES);
    localparam int CHUNK_W = 10;
    localparam int CHUNKS  = FRAME_W / CHUNK_W;
    localparam int STEP_W  = 2 * CHUNK_W;
    localparam int RECIP_W = 31;
    localparam int SHIFT   = STEP_W + CHUNK_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + longint'(TABLE_PAGES) - 1) / longint'(TABLE_PAGES));
    localparam logic [CHUNK_W:0] DIVISOR = (CHUNK_W + 1)'(TABLE_PAGES);

    logic                      active_reg, active_next;
    logic                      phase_reg, phase_next;
    logic                      done_reg, done_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic [FRAME_W-1:0]        src_reg, src_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [STEP_W-1:0]         est_reg, est_next;
    logic [PW-1:0]             rem_reg, rem_next;
    logic [STEP_W-1:0]         step_val;
    logic [STEP_W+RECIP_W-1:0] est_prod;
    logic [STEP_W+CHUNK_W:0]   back_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        step_reg <= step_next;
        est_reg  <= est_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        src_next    = src_reg;
        step_next   = step_reg;
        est_next    = est_reg;
        rem_next    = rem_reg;
        step_val    = {CHUNK_W'(rem_reg), src_reg[FRAME_W-1 -: CHUNK_W]};
        est_prod    = step_val * RECIP;
        back_prod   = est_reg * DIVISOR;
        if (start)
        begin
            active_next = 1'b1;
            phase_next  = 1'b0;
            cnt_next    = 2'(CHUNKS - 1);
            src_next    = dividend;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            if (!phase_reg)
            begin
                step_next  = step_val;
                est_next   = est_prod[SHIFT +: STEP_W];
                src_next   = {src_reg[FRAME_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = PW'(step_reg - back_prod[STEP_W-1:0]);
                phase_next = 1'b0;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == 2'd0)
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/page_table_range_mapper_top.sv =====
// Page table range mapper: walks and fills a four-level table tree held in a local pool.
// Depends on ptrm_pkg, ptrm_table_ram and ptrm_frame_mod.
// After reset the table memory is cleared, all TABLE_PAGES*512 entries, while busy is high.
// Per page an item does four table reads and checks, one per level; each table
// allocated is zeroed entry by entry and then linked, and each link outside the
// pool waits on ptrm_frame_mod. One result strobe follows each item.
module page_table_range_mapper_top
    import ptrm_pkg::*;
#(
    parameter int TABLE_PAGES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + SLOT_W;
    localparam int DEPTH = TABLE_PAGES * (2 ** SLOT_W);
    localparam int CW    = $clog2(TABLE_PAGES + 1);

    state_t             state_reg, state_next;
    level_t             level_reg, level_next;
    status_t            status_reg, status_next;
    logic [PW-1:0]      page_reg, page_next;
    logic [VPN_W-1:0]   vpn_reg, vpn_next;
    logic [FRAME_W-1:0] ppn_reg, ppn_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0] mapped_reg, mapped_next;
    logic [COUNT_W-1:0] already_reg, already_next;
    logic [CW-1:0]      next_free_reg, next_free_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic [FRAME_W-1:0] base_reg;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr, entry_addr;
    entry_t             rd_data, wr_data;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] diff;
    logic               mod_start, mod_done;
    logic [PW-1:0]      mod_rem;
    logic [16:0]        top_bits;
    logic [SIZE_W-1:0]  size_sat;
    logic [31:0]        span;

    ptrm_table_ram #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ptrm_frame_mod #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (diff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[3] == CFG_IDX_POOL_BASE))
        begin
            base_reg <= pwdata[FRAME_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == CFG_IDX_POOL_BASE) ? {24'd0, base_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            level_reg     <= LVL_4;
            status_reg    <= STATUS_OK;
            page_reg      <= '0;
            remain_reg    <= '0;
            mapped_reg    <= '0;
            already_reg   <= '0;
            next_free_reg <= CW'(1);
            sweep_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            status_reg    <= status_next;
            page_reg      <= page_next;
            remain_reg    <= remain_next;
            mapped_reg    <= mapped_next;
            already_reg   <= already_next;
            next_free_reg <= next_free_next;
            sweep_reg     <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vpn_reg <= vpn_next;
        ppn_reg <= ppn_next;
    end

    always_comb
    begin
        case (level_reg)
            LVL_4:   slot = vpn_reg[35:27];
            LVL_3:   slot = vpn_reg[26:18];
            LVL_2:   slot = vpn_reg[17:9];
            default: slot = vpn_reg[8:0];
        endcase
    end

    assign entry_addr = {page_reg, slot};
    assign diff       = rd_data.frame - base_reg;
    assign top_bits   = cmd.virt_addr[63:47];
    assign size_sat   = (cmd.size_bytes > MAX_LEN) ? MAX_LEN : cmd.size_bytes;
    assign span       = 32'(cmd.virt_addr[11:0]) + 32'(size_sat) + 32'd4095;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        status_next    = status_reg;
        page_next      = page_reg;
        vpn_next       = vpn_reg;
        ppn_next       = ppn_reg;
        remain_next    = remain_reg;
        mapped_next    = mapped_reg;
        already_next   = already_reg;
        next_free_next = next_free_reg;
        sweep_next     = sweep_reg;
        rd_en          = 1'b0;
        rd_addr        = entry_addr;
        wr_en          = 1'b0;
        wr_addr        = entry_addr;
        wr_data        = '0;
        mod_start      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    mapped_next  = '0;
                    already_next = '0;
                    level_next   = LVL_4;
                    page_next    = '0;
                    vpn_next     = cmd.virt_addr[47:12];
                    ppn_next     = cmd.phys_addr[51:12];
                    remain_next  = COUNT_W'(span[31:12]);
                    if (!((&top_bits) || (~|top_bits)))
                    begin
                        status_next = STATUS_NONCANON;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        if (span[31:12] == 20'd0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (level_reg != LVL_1)
                begin
                    if (!rd_data.valid)
                    begin
                        if (next_free_reg >= CW'(TABLE_PAGES))
                        begin
                            status_next = STATUS_POOL_EMPTY;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            sweep_next = '0;
                            state_next = ST_ZERO;
                        end
                    end
                    else if (diff < FRAME_W'(TABLE_PAGES))
                    begin
                        page_next  = diff[PW-1:0];
                        level_next = level_t'(level_reg + 1'b1);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end
                end
                else
                begin
                    if (!rd_data.valid)
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.frame = ppn_reg;
                        mapped_next   = mapped_reg + 1'b1;
                    end
                    else
                    begin
                        already_next = already_reg + 1'b1;
                    end
                    vpn_next    = vpn_reg + 1'b1;
                    ppn_next    = ppn_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    level_next  = LVL_4;
                    page_next   = '0;
                    if (remain_reg == COUNT_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    page_next  = mod_rem;
                    level_next = level_t'(level_reg + 1'b1);
                    state_next = ST_READ;
                end
            end

            ST_ZERO:
            begin
                wr_en      = 1'b1;
                wr_addr    = {next_free_reg[PW-1:0], sweep_reg[SLOT_W-1:0]};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[SLOT_W-1:0] == {SLOT_W{1'b1}})
                begin
                    sweep_next = '0;
                    state_next = ST_LINK;
                end
            end

            ST_LINK:
            begin
                wr_en          = 1'b1;
                wr_data.valid  = 1'b1;
                wr_data.frame  = base_reg + FRAME_W'(next_free_reg);
                page_next      = next_free_reg[PW-1:0];
                next_free_next = next_free_reg + 1'b1;
                level_next     = level_t'(level_reg + 1'b1);
                state_next     = ST_READ;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy                        = (state_reg != ST_IDLE);
    assign done                        = (state_reg == ST_DONE);
    assign result.status               = status_reg;
    assign result.pages_mapped         = mapped_reg;
    assign result.pages_already_mapped = already_reg;
    assign result.tables_in_use        = TIU_W'(next_free_reg);

endmodule
